// ===== rtl/apq_pkg.sv =====
package apq_pkg;

	// Queue geometry and field widths.
	localparam int CAPACITY    = 64;
	localparam int VERTEX_BITS = 10;
	localparam int COST_BITS   = 24;
	localparam int KEY_BITS    = COST_BITS + 1;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int STATUS_BITS = 2;

	// Operation codes carried in the request word.
	typedef enum logic {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

// ===== rtl/apq_if.sv =====
// Request channel: one put or get word.
interface apq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [apq_pkg::VERTEX_BITS-1:0]   vertex_id;
	logic [apq_pkg::COST_BITS-1:0]     path_cost;
	logic [apq_pkg::COST_BITS-1:0]     heuristic;

	modport source (output valid, opcode, vertex_id, path_cost, heuristic, input ready);
	modport sink   (input valid, opcode, vertex_id, path_cost, heuristic, output ready);
endinterface

// Response channel: one result word per request.
interface apq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [apq_pkg::STATUS_BITS-1:0]   status;
	logic [apq_pkg::VERTEX_BITS-1:0]   out_vertex;
	logic [apq_pkg::COST_BITS-1:0]     out_cost;
	logic [apq_pkg::COST_BITS-1:0]     out_heuristic;
	logic [apq_pkg::COUNT_BITS-1:0]    entry_count;

	modport source (output valid, status, out_vertex, out_cost, out_heuristic, entry_count,
		input ready);
	modport sink   (input valid, status, out_vertex, out_cost, out_heuristic, entry_count,
		output ready);
endinterface

// ===== rtl/apq_ctrl.sv =====
module apq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_opcode,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  apq_pkg::dp_stat_t dp_stat,
	output apq_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A new word is taken whenever the output register is free or drains now.
	assign req_ready = (state_q == S_IDLE) || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == S_HOLD);

	// The datapath only needs to know that a word is taken and which operation it is.
	// The full and empty flags are decoded there; they are passed up for visibility.
	always_comb begin
		cmd.load = accept && (dp_stat.full || !dp_stat.full);
		cmd.op   = apq_pkg::op_t'(req_opcode);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (accept) state_d = S_HOLD;
				else if (rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== rtl/apq_datapath.sv =====
module apq_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  apq_pkg::cmd_t                   cmd,
	output apq_pkg::dp_stat_t               dp_stat,
	input  logic [apq_pkg::VERTEX_BITS-1:0] vertex_id,
	input  logic [apq_pkg::COST_BITS-1:0]   path_cost,
	input  logic [apq_pkg::COST_BITS-1:0]   heuristic,
	output logic [apq_pkg::STATUS_BITS-1:0] status,
	output logic [apq_pkg::VERTEX_BITS-1:0] out_vertex,
	output logic [apq_pkg::COST_BITS-1:0]   out_cost,
	output logic [apq_pkg::COST_BITS-1:0]   out_heuristic,
	output logic [apq_pkg::COUNT_BITS-1:0]  entry_count
);

	localparam int CAP = apq_pkg::CAPACITY;

	// Sorted cells, front at index 0. Each cell keeps its key so no adder sits per cell.
	logic [apq_pkg::VERTEX_BITS-1:0] vtx_q  [CAP];
	logic [apq_pkg::COST_BITS-1:0]   cost_q [CAP];
	logic [apq_pkg::COST_BITS-1:0]   heur_q [CAP];
	logic [apq_pkg::KEY_BITS-1:0]    key_q  [CAP];
	logic [apq_pkg::COUNT_BITS-1:0]  count_q;
	logic [apq_pkg::COUNT_BITS-1:0]  count_d;

	logic [apq_pkg::KEY_BITS-1:0] new_key;
	logic [CAP-1:0]               le;
	logic                         full;
	logic                         empty;
	logic                         do_put;
	logic                         do_get;

	assign new_key = {1'b0, path_cost} + {1'b0, heuristic};
	assign full    = (count_q == apq_pkg::COUNT_BITS'(CAP));
	assign empty   = (count_q == '0);
	assign do_put  = cmd.load && (cmd.op == apq_pkg::OP_PUT) && !full;
	assign do_get  = cmd.load && (cmd.op == apq_pkg::OP_GET) && !empty;

	assign dp_stat.full  = full;
	assign dp_stat.empty = empty;

	// Each held cell compares its key with the new one; the true bits form a prefix.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			le[i] = (apq_pkg::COUNT_BITS'(i) < count_q) && (key_q[i] <= new_key);
		end
	end

	// Per-cell update: keep, take the new word, or take the neighbor's contents.
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic ins_here;
		logic from_prev;

		if (g == 0) begin : g_front
			assign ins_here  = !le[g];
			assign from_prev = 1'b0;
		end else begin : g_rest
			assign ins_here  = !le[g] && le[g-1];
			assign from_prev = !le[g] && !le[g-1];
		end

		always_ff @(posedge clk) begin
			if (do_put && ins_here) begin
				vtx_q[g]  <= vertex_id;
				cost_q[g] <= path_cost;
				heur_q[g] <= heuristic;
				key_q[g]  <= new_key;
			end else if (do_put && from_prev) begin
				vtx_q[g]  <= vtx_q[(g > 0) ? g - 1 : 0];
				cost_q[g] <= cost_q[(g > 0) ? g - 1 : 0];
				heur_q[g] <= heur_q[(g > 0) ? g - 1 : 0];
				key_q[g]  <= key_q[(g > 0) ? g - 1 : 0];
			end else if (do_get && (g < CAP - 1)) begin
				vtx_q[g]  <= vtx_q[(g < CAP - 1) ? g + 1 : g];
				cost_q[g] <= cost_q[(g < CAP - 1) ? g + 1 : g];
				heur_q[g] <= heur_q[(g < CAP - 1) ? g + 1 : g];
				key_q[g]  <= key_q[(g < CAP - 1) ? g + 1 : g];
			end
		end
	end

	// Fill count.
	always_comb begin
		count_d = count_q;
		if (do_put) count_d = count_q + 1'b1;
		else if (do_get) count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else count_q <= count_d;
	end

	// Result word, captured when a request word is taken.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_count   <= count_d;
			out_vertex    <= '0;
			out_cost      <= '0;
			out_heuristic <= '0;
			status        <= apq_pkg::STAT_OK;
			if (cmd.op == apq_pkg::OP_PUT) begin
				if (full) status <= apq_pkg::STAT_FULL;
			end else if (empty) begin
				status <= apq_pkg::STAT_EMPTY;
			end else begin
				out_vertex    <= vtx_q[0];
				out_cost      <= cost_q[0];
				out_heuristic <= heur_q[0];
			end
		end
	end

endmodule

// ===== rtl/astar_priority_queue_top.sv =====
// Bounded min-priority queue for A* search, kept as a sorted row of cells.
// Request channel (req): opcode 0 puts vertex_id, path_cost and heuristic;
// opcode 1 gets the entry with the smallest path_cost + heuristic. Equal keys
// leave in arrival order.
// Response channel (rsp): exactly one word per request, carrying status
// (ok, get on empty, put on full and dropped), the removed entry for a good
// get (zeros otherwise) and entry_count after the operation.
// A request taken in one cycle has its registered response valid in the next.
// Throughput is one request per cycle while the receiver does not stall;
// every cell compares its stored key with the new key in the same cycle and
// then shifts or loads. The response sits in an output register. When the
// receiver stalls, one response is held and req.ready follows rsp.ready, so
// a new request is taken in the same cycle that the held response drains.
// Reset empties the queue and clears the response valid. The cells themselves
// are not cleared; only the first entry_count cells are ever read.
module astar_priority_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	apq_req_if.sink   req,
	apq_rsp_if.source rsp
);

	apq_pkg::cmd_t     cmd;
	apq_pkg::dp_stat_t dp_stat;

	apq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.dp_stat    (dp_stat),
		.cmd        (cmd)
	);

	apq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_stat       (dp_stat),
		.vertex_id     (req.vertex_id),
		.path_cost     (req.path_cost),
		.heuristic     (req.heuristic),
		.status        (rsp.status),
		.out_vertex    (rsp.out_vertex),
		.out_cost      (rsp.out_cost),
		.out_heuristic (rsp.out_heuristic),
		.entry_count   (rsp.entry_count)
	);

endmodule

// ===== rtl/apq_checker.sv =====
module apq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [apq_pkg::STATUS_BITS-1:0] status,
	input logic [apq_pkg::VERTEX_BITS-1:0] out_vertex,
	input logic [apq_pkg::COUNT_BITS-1:0]  entry_count
);

	// Every taken request has its response valid in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> rsp_valid)
		else $error("request taken without a response on the next cycle");

	// A stalled response stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped while stalled");

	// A get on an empty queue reports no entry and a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == apq_pkg::STAT_EMPTY) |-> (entry_count == '0 && out_vertex == '0))
		else $error("empty status with entry data or nonzero count");

	// A dropped put is only reported with the queue at capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == apq_pkg::STAT_FULL)
		|-> (entry_count == apq_pkg::COUNT_BITS'(apq_pkg::CAPACITY)))
		else $error("full status while the queue is not at capacity");

	// The count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count <= apq_pkg::COUNT_BITS'(apq_pkg::CAPACITY)))
		else $error("entry count beyond capacity");

endmodule

bind astar_priority_queue_top apq_checker u_apq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.out_vertex  (rsp.out_vertex),
	.entry_count (rsp.entry_count)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_WORDS  = 1850;
	localparam int IDLE_PHASES   = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [apq_pkg::COST_BITS-1:0] COST_MAX = '1;

	typedef logic [apq_pkg::VERTEX_BITS-1:0] vertex_t;
	typedef logic [apq_pkg::COST_BITS-1:0]   cost_t;
	typedef logic [apq_pkg::KEY_BITS-1:0]    key_t;
	typedef logic [apq_pkg::COUNT_BITS-1:0]  count_t;

	// One response word as the queue should return it.
	typedef struct {
		apq_pkg::status_t status;
		vertex_t          vertex;
		cost_t            cost;
		cost_t            heur;
		count_t           count;
	} pq_result_t;

	// One entry held in the queue.
	typedef struct {
		vertex_t vertex;
		cost_t   cost;
		cost_t   heur;
	} pq_entry_t;

	// One row of the directed table; fixed rows carry their own expected word.
	typedef struct {
		apq_pkg::op_t op;
		vertex_t      vertex;
		cost_t        cost;
		cost_t        heur;
		logic         fixed;
		pq_result_t   result;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	apq_req_if req_if();
	apq_rsp_if rsp_if();

	astar_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	assign rsp_if.ready = sink_ready;

	// Fixed expectation travels next to the request word it belongs to.
	logic       word_fixed = 1'b0;
	pq_result_t word_result;

	// Shadow copy of the sorted queue.
	pq_entry_t   held[apq_pkg::CAPACITY];
	int unsigned held_fill = 0;

	pq_result_t  pending_results[$];
	stim_row_t   directed_rows[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          sender_idle_pct = 0;
	int          sink_stall_pct = 0;

	always #CLK_HALF clk = ~clk;

	// Apply one put or get to the shadow queue and return the word it yields.
	function automatic pq_result_t sorted_queue_op(apq_pkg::op_t op, vertex_t v, cost_t c,
		cost_t h);
		pq_result_t r;
		key_t       k;
		int         pos;
		r.status = apq_pkg::STAT_OK;
		r.vertex = '0;
		r.cost   = '0;
		r.heur   = '0;
		if (op == apq_pkg::OP_PUT) begin
			if (held_fill >= apq_pkg::CAPACITY) begin
				r.status = apq_pkg::STAT_FULL;
			end else begin
				k = {1'b0, c} + {1'b0, h};
				pos = 0;
				// Equal keys go behind the ones already held.
				while (pos < held_fill &&
					({1'b0, held[pos].cost} + {1'b0, held[pos].heur}) <= k)
					pos++;
				for (int i = held_fill; i > pos; i--)
					held[i] = held[i-1];
				held[pos].vertex = v;
				held[pos].cost   = c;
				held[pos].heur   = h;
				held_fill++;
			end
		end else begin
			if (held_fill == 0) begin
				r.status = apq_pkg::STAT_EMPTY;
			end else begin
				r.vertex = held[0].vertex;
				r.cost   = held[0].cost;
				r.heur   = held[0].heur;
				for (int i = 1; i < held_fill; i++)
					held[i-1] = held[i];
				held_fill--;
			end
		end
		r.count = count_t'(held_fill);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic add_row(input apq_pkg::op_t op, input vertex_t v, input cost_t c,
		input cost_t h);
		stim_row_t row;
		row.op     = op;
		row.vertex = v;
		row.cost   = c;
		row.heur   = h;
		row.fixed  = 1'b0;
		row.result = '{apq_pkg::STAT_OK, '0, '0, '0, '0};
		directed_rows.push_back(row);
	endtask

	task automatic add_fixed_row(input apq_pkg::op_t op, input vertex_t v, input cost_t c,
		input cost_t h, input apq_pkg::status_t st, input vertex_t ov, input cost_t oc,
		input cost_t oh, input count_t cnt);
		stim_row_t row;
		row.op     = op;
		row.vertex = v;
		row.cost   = c;
		row.heur   = h;
		row.fixed  = 1'b1;
		row.result = '{st, ov, oc, oh, cnt};
		directed_rows.push_back(row);
	endtask

	// Pick a cost or heuristic; mode 1 gives many equal keys, mode 2 the extremes.
	function automatic cost_t pick_cost(int mode);
		cost_t c;
		case (mode)
			1: begin
				c = cost_t'($urandom_range(3)) << 8;
			end
			2: begin
				case ($urandom_range(2))
					0: c = '0;
					1: c = COST_MAX;
					default: c = cost_t'($urandom);
				endcase
			end
			default: begin
				c = cost_t'($urandom);
			end
		endcase
		return c;
	endfunction

	// Offer one request word, with random gaps before it in idling phases.
	task automatic send_word(input stim_row_t row);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.opcode    <= row.op;
		req_if.vertex_id <= row.vertex;
		req_if.path_cost <= row.cost;
		req_if.heuristic <= row.heur;
		word_fixed       <= row.fixed;
		word_result      <= row.result;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Hold the sender back until every pending response has come.
	task automatic wait_all_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stalls at random in the stalling phases.
	always @(posedge clk) begin
		sink_ready <= !(sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct);
	end

	// Watch both channels: check responses, then predict for accepted requests.
	always @(posedge clk) begin
		pq_result_t want;
		pq_result_t got;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("response word with nothing pending");
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.status != want.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							rsp_if.status, want.status));
					if (rsp_if.out_vertex != want.vertex)
						flag_mismatch($sformatf("out_vertex got %0d want %0d",
							rsp_if.out_vertex, want.vertex));
					if (rsp_if.out_cost != want.cost)
						flag_mismatch($sformatf("out_cost got %h want %h",
							rsp_if.out_cost, want.cost));
					if (rsp_if.out_heuristic != want.heur)
						flag_mismatch($sformatf("out_heuristic got %h want %h",
							rsp_if.out_heuristic, want.heur));
					if (rsp_if.entry_count != want.count)
						flag_mismatch($sformatf("entry_count got %0d want %0d",
							rsp_if.entry_count, want.count));
				end
			end
			if (req_if.valid && req_if.ready) begin
				got = sorted_queue_op(apq_pkg::op_t'(req_if.opcode), req_if.vertex_id,
					req_if.path_cost, req_if.heuristic);
				pending_results.push_back(word_fixed ? word_result : got);
			end
		end
	end

	// Cycle budget for the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        sent;
		int        phase;
		int        cur_phase;
		int        burst_len;
		int        put_pct;
		int        key_mode;

		req_if.valid     <= 1'b0;
		req_if.opcode    <= apq_pkg::OP_PUT;
		req_if.vertex_id <= '0;
		req_if.path_cost <= '0;
		req_if.heuristic <= '0;
		word_result      <= '{apq_pkg::STAT_OK, '0, '0, '0, '0};

		// Empty queue, extreme keys, equal keys in arrival order, and draining.
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_EMPTY, '0, '0, '0, 0);
		add_fixed_row(apq_pkg::OP_PUT, 10'd1023, COST_MAX, COST_MAX, apq_pkg::STAT_OK,
			'0, '0, '0, 1);
		add_fixed_row(apq_pkg::OP_PUT, 10'd0, '0, '0, apq_pkg::STAT_OK, '0, '0, '0, 2);
		add_fixed_row(apq_pkg::OP_PUT, 10'd5, COST_MAX, '0, apq_pkg::STAT_OK,
			'0, '0, '0, 3);
		add_fixed_row(apq_pkg::OP_PUT, 10'd6, '0, COST_MAX, apq_pkg::STAT_OK,
			'0, '0, '0, 4);
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_OK, 10'd0, '0, '0, 3);
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_OK,
			10'd5, COST_MAX, '0, 2);
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_OK,
			10'd6, '0, COST_MAX, 1);
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_OK,
			10'd1023, COST_MAX, COST_MAX, 0);
		add_fixed_row(apq_pkg::OP_GET, '0, '0, '0, apq_pkg::STAT_EMPTY, '0, '0, '0, 0);
		// Alternating bit patterns, a key that carries into the top bit, three-way tie.
		add_row(apq_pkg::OP_PUT, 10'h2AA, 24'hAAAAAA, 24'h555555);
		add_row(apq_pkg::OP_PUT, 10'h155, 24'h555555, 24'hAAAAAA);
		add_row(apq_pkg::OP_PUT, 10'h3FF, 24'h800000, 24'h800000);
		add_row(apq_pkg::OP_PUT, 10'h001, 24'h000100, 24'h000000);
		add_row(apq_pkg::OP_PUT, 10'h200, 24'h7FFFFF, 24'h800000);
		repeat (6)
			add_row(apq_pkg::OP_GET, '0, '0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i]);
		wait_all_results();

		// Random bursts: put-heavy ones fill the queue to full, get-heavy ones empty it.
		sent = 0;
		cur_phase = -1;
		row.fixed  = 1'b0;
		row.result = '{apq_pkg::STAT_OK, '0, '0, '0, '0};
		while (sent < RANDOM_WORDS) begin
			burst_len = $urandom_range(140, 20);
			case ($urandom_range(2))
				0: put_pct = 85;
				1: put_pct = 15;
				default: put_pct = 50;
			endcase
			key_mode = $urandom_range(2);
			for (int n = 0; n < burst_len && sent < RANDOM_WORDS; n++) begin
				phase = (sent * 2 * IDLE_PHASES / RANDOM_WORDS) % IDLE_PHASES;
				if (phase != cur_phase) begin
					// Let the queue settle before the idling pattern changes.
					wait_all_results();
					cur_phase = phase;
					case (phase)
						0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
						1: begin sender_idle_pct = 67; sink_stall_pct = 0;  end
						2: begin sender_idle_pct = 0;  sink_stall_pct = 67; end
						default: begin sender_idle_pct = 34; sink_stall_pct = 34; end
					endcase
				end
				row.op     = ($urandom_range(99) < put_pct) ? apq_pkg::OP_PUT : apq_pkg::OP_GET;
				row.vertex = vertex_t'($urandom);
				row.cost   = pick_cost(key_mode);
				row.heur   = pick_cost(key_mode);
				send_word(row);
				sent++;
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/apq_pkg.sv
rtl/apq_if.sv
rtl/apq_ctrl.sv
rtl/apq_datapath.sv
rtl/astar_priority_queue_top.sv
rtl/apq_checker.sv
test/testbench.sv
